@@ rtl/core/gpdz_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad deadzone shaper package
// Shared types, register indices, reset values and report layout constants.
// ----------------------------------------------------------------------------
package gpdz_pkg;

    localparam int AXIS_COUNT    = 6;
    localparam int AXIS_IDX_W    = $clog2(AXIS_COUNT);
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [2:0] AX_LT = 3'd0;
    localparam logic [2:0] AX_RT = 3'd1;
    localparam logic [2:0] AX_LX = 3'd2;
    localparam logic [2:0] AX_LY = 3'd3;
    localparam logic [2:0] AX_RX = 3'd4;
    localparam logic [2:0] AX_RY = 3'd5;

    localparam logic [7:0] MAIN_REPORT_LEN   = 8'd8;
    localparam logic [7:0] SECOND_REPORT_LEN = 8'd4;

    localparam logic [2:0] CFG_REPORT_ID  = 3'd0;
    localparam logic [2:0] CFG_LINK_TMO   = 3'd1;
    localparam logic [2:0] CFG_DEAD_LOW   = 3'd2;
    localparam logic [2:0] CFG_DEAD_HIGH  = 3'd3;
    localparam logic [2:0] CFG_FULL_SCALE = 3'd4;

    localparam logic [7:0]  RST_REPORT_ID  = 8'd0;
    localparam logic [31:0] RST_LINK_TMO   = 32'd100;
    localparam logic [14:0] RST_DEAD_LOW   = 15'd1000;
    localparam logic [14:0] RST_DEAD_HIGH  = 15'd30000;
    localparam logic [14:0] RST_FULL_SCALE = 15'd1000;

    typedef struct packed {
        logic [0:0]  kind;
        logic [31:0] now_ms;
        logic [7:0]  msg_id;
        logic [7:0]  msg_length;
        logic [63:0] payload;
        logic [2:0]  axis;
    } req_item_t;

    typedef struct packed {
        logic               connected;
        logic [15:0]        buttons;
        logic signed [15:0] raw_value;
        logic signed [15:0] shaped_value;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0]  report_id;
        logic [31:0] link_timeout_ms;
        logic [14:0] dead_low;
        logic [14:0] dead_high;
        logic [14:0] full_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_MAIN,
        OP_SECOND,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        len_ok;
        logic [31:0] now_ms;
        logic [63:0] payload;
        logic [2:0]  axis;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic dividing;
    } back_status_t;

endpackage

@@ rtl/core/gpdz_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad deadzone shaper front end
// Accepts request beats, classifies them and queues the ones that matter.
// ----------------------------------------------------------------------------
module gpdz_front
    import gpdz_pkg::*;
(
    input  cfg_t      cfg,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_data,
    input  logic      q_full,
    output logic      q_push,
    output cmd_t      q_entry
);

    logic [7:0] second_id;
    logic       keep;

    assign second_id = cfg.report_id + 8'd1;

    always_comb
    begin
        keep           = 1'b1;
        q_entry.op     = OP_QUERY;
        q_entry.len_ok = 1'b0;
        q_entry.now_ms = req_data.now_ms;
        q_entry.payload = req_data.payload;
        q_entry.axis   = req_data.axis;
        if (req_data.kind == 1'b0)
        begin
            if (req_data.msg_id == cfg.report_id)
            begin
                q_entry.op     = OP_MAIN;
                q_entry.len_ok = (req_data.msg_length == MAIN_REPORT_LEN);
            end
            else if (req_data.msg_id == second_id)
            begin
                q_entry.op     = OP_SECOND;
                q_entry.len_ok = (req_data.msg_length == SECOND_REPORT_LEN);
            end
            else
            begin
                keep = 1'b0;
            end
        end
    end

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full && keep;

endmodule

@@ rtl/core/gpdz_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad deadzone shaper command queue
// Short shifting queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module gpdz_queue
    import gpdz_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_entry,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] wr_idx;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[0];
    assign wr_idx     = pop ? (count_reg - CW'(1)) : count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        if (i < DEPTH - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (push && wr_idx == CW'(i))
                begin
                    slot_reg[i] <= push_entry;
                end
                else if (pop)
                begin
                    slot_reg[i] <= slot_reg[i + 1];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (push && wr_idx == CW'(i))
                begin
                    slot_reg[i] <= push_entry;
                end
            end
        end
    end

endmodule

@@ rtl/core/gpdz_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad deadzone shaper back end
// Holds controller state, applies reports and answers queries with shaping.
// ----------------------------------------------------------------------------
module gpdz_back
    import gpdz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  cmd_t         q_head,
    output logic         q_pop,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output rsp_item_t    rsp_data,
    output back_status_t status
);

    back_state_t state_reg, state_next;

    logic [15:0]      buttons_reg;
    logic [15:0]      axis_reg [AXIS_COUNT];
    logic [31:0]      last_seen_reg;

    logic             rsp_valid_reg;
    rsp_item_t        rsp_data_reg;

    logic [14:0]      num_reg;
    logic [14:0]      span_reg;
    logic [14:0]      fs_reg;
    logic             neg_reg;
    rsp_item_t        hold_reg;
    logic [14:0]      rem_reg;
    logic [14:0]      quo_reg;
    logic [3:0]       step_reg;

    logic             is_query;
    logic             conn;
    logic             axis_ok;
    logic             is_trigger;
    logic signed [15:0] raw;
    logic [15:0]      mag;
    logic             in_dead;
    logic             clamp;
    logic             needs_div;
    rsp_item_t        quick;
    rsp_item_t        div_result;
    logic             out_free;
    logic [29:0]      product;
    logic [15:0]      shifted;
    logic [16:0]      trial;
    logic [14:0]      quo_final;

    logic             apply_report;
    logic             load_quick;
    logic             start_div;
    logic             do_mul;
    logic             do_step;
    logic             load_div;

    assign is_query   = (q_head.op == OP_QUERY);
    assign conn       = ((q_head.now_ms - last_seen_reg) <= cfg.link_timeout_ms);
    assign axis_ok    = (q_head.axis <= AX_RY);
    assign is_trigger = (q_head.axis == AX_LT) || (q_head.axis == AX_RT);
    assign raw        = axis_ok ? $signed(axis_reg[q_head.axis[AXIS_IDX_W-1:0]]) : 16'sd0;
    assign mag        = raw[15] ? (16'd0 - raw) : raw;
    assign in_dead    = (mag <= {1'b0, cfg.dead_low});
    assign clamp      = (mag > {1'b0, cfg.dead_high});
    assign needs_div  = is_query && conn && axis_ok && !is_trigger && !in_dead && !clamp;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        quick = '0;
        if (conn)
        begin
            quick.connected = 1'b1;
            quick.buttons   = buttons_reg;
            quick.raw_value = raw;
            if (is_trigger || !axis_ok || in_dead)
            begin
                quick.shaped_value = is_trigger ? raw : 16'sd0;
            end
            else
            begin
                quick.shaped_value = raw[15] ? -$signed({1'b0, cfg.full_scale})
                                             : $signed({1'b0, cfg.full_scale});
            end
        end
    end

    assign product   = num_reg * fs_reg;
    assign shifted   = {rem_reg, quo_reg[14]};
    assign trial     = {1'b0, shifted} - {2'b00, span_reg};
    assign quo_final = quo_reg;

    always_comb
    begin
        div_result              = hold_reg;
        div_result.shaped_value = neg_reg ? -$signed({1'b0, quo_final})
                                          : $signed({1'b0, quo_final});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && needs_div)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (step_reg == 4'd14)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        apply_report = 1'b0;
        load_quick   = 1'b0;
        start_div    = 1'b0;
        do_mul       = 1'b0;
        do_step      = 1'b0;
        load_div     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (!is_query)
                    begin
                        apply_report = 1'b1;
                    end
                    else if (needs_div)
                    begin
                        start_div = 1'b1;
                    end
                    else if (out_free)
                    begin
                        load_quick = 1'b1;
                    end
                end
            end
            BK_MUL:
            begin
                do_mul = 1'b1;
            end
            BK_DIV:
            begin
                do_step = 1'b1;
            end
            BK_DONE:
            begin
                load_div = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign q_pop = apply_report || load_quick || start_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
            buttons_reg   <= '0;
            last_seen_reg <= '0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                axis_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_quick || load_div)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (apply_report)
            begin
                last_seen_reg <= q_head.now_ms;
                if (q_head.len_ok)
                begin
                    if (q_head.op == OP_MAIN)
                    begin
                        buttons_reg    <= q_head.payload[15:0];
                        axis_reg[AX_LT[AXIS_IDX_W-1:0]] <= {8'd0, q_head.payload[23:16]};
                        axis_reg[AX_RT[AXIS_IDX_W-1:0]] <= {8'd0, q_head.payload[31:24]};
                        axis_reg[AX_LX[AXIS_IDX_W-1:0]] <= q_head.payload[47:32];
                        axis_reg[AX_LY[AXIS_IDX_W-1:0]] <= q_head.payload[63:48];
                    end
                    else
                    begin
                        axis_reg[AX_RX[AXIS_IDX_W-1:0]] <= q_head.payload[15:0];
                        axis_reg[AX_RY[AXIS_IDX_W-1:0]] <= q_head.payload[31:16];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_quick)
        begin
            rsp_data_reg <= quick;
        end
        else if (load_div)
        begin
            rsp_data_reg <= div_result;
        end
        if (start_div)
        begin
            num_reg  <= mag[14:0] - cfg.dead_low;
            span_reg <= cfg.dead_high - cfg.dead_low;
            fs_reg   <= cfg.full_scale;
            neg_reg  <= raw[15];
            hold_reg <= quick;
        end
        if (do_mul)
        begin
            rem_reg  <= product[29:15];
            quo_reg  <= product[14:0];
            step_reg <= '0;
        end
        if (do_step)
        begin
            step_reg <= step_reg + 4'd1;
            if (!trial[16])
            begin
                rem_reg <= trial[14:0];
                quo_reg <= {quo_reg[13:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[14:0];
                quo_reg <= {quo_reg[13:0], 1'b0};
            end
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_data        = rsp_data_reg;
    assign status.busy     = (state_reg != BK_IDLE);
    assign status.dividing = (state_reg == BK_DIV) || (state_reg == BK_MUL);

endmodule

@@ rtl/core/gamepad_report_deadzone_shaper_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report deadzone shaper
// Keeps controller state from report messages and answers axis queries.
// ----------------------------------------------------------------------------
// Usage: request beats (req_valid/req_stall/req_data) are either report
// messages or queries. Reports with the main or second report id update the
// stored state and produce no response; other ids are dropped. Each query
// yields one response beat on rsp_valid/rsp_stall/rsp_data. The user must
// write registers through cfg_valid/cfg_ready/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. A front end classifies beats
// into a short command queue; a back end executes them in order. A trigger,
// deadzoned, clamped or disconnected query is answered from the queue head
// into the response register; a stick query in the rescale range first passes
// through a multiply state and a fifteen-step restoring divider in the back end.
// Reset clears the state, the queue and the response valid flag and restores
// the register defaults. When the receiver stalls, the response is held and
// the queue fills; req_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module gamepad_report_deadzone_shaper_unit
    import gpdz_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_item_t   req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_item_t   rsp_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t         cfg_reg;
    logic         q_full;
    logic         q_push;
    cmd_t         q_entry;
    logic         q_pop;
    logic         q_valid;
    cmd_t         q_head;
    back_status_t back_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_id       <= RST_REPORT_ID;
            cfg_reg.link_timeout_ms <= RST_LINK_TMO;
            cfg_reg.dead_low        <= RST_DEAD_LOW;
            cfg_reg.dead_high       <= RST_DEAD_HIGH;
            cfg_reg.full_scale      <= RST_FULL_SCALE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REPORT_ID:  cfg_reg.report_id       <= cfg_data[7:0];
                CFG_LINK_TMO:   cfg_reg.link_timeout_ms <= cfg_data;
                CFG_DEAD_LOW:   cfg_reg.dead_low        <= cfg_data[14:0];
                CFG_DEAD_HIGH:  cfg_reg.dead_high       <= cfg_data[14:0];
                CFG_FULL_SCALE: cfg_reg.full_scale      <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    gpdz_front u_front (
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    gpdz_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    gpdz_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .status    (back_status)
    );

    a_link_down_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.connected |->
            rsp_data.buttons == '0 && rsp_data.raw_value == '0 &&
            rsp_data.shaped_value == '0)
        else $error("Disconnected response carries non-zero data");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("Command queue written while full");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !back_status.busy)
        else $error("Back end took a command it could not hold");

    a_no_result_mid_divide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(back_status.dividing))
        else $error("Response raised while the divider was running");

endmodule

@@ test/gamepad_report_deadzone_shaper_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report deadzone shaper testbench
// Drives report and query beats with random gaps and response back-pressure,
// predicts every query response from a model of the stored controller state,
// and compares each response field by field. Registers are reprogrammed
// between phases while the block is idle, covering the extreme settings.
// ----------------------------------------------------------------------------
module gamepad_report_deadzone_shaper_unit_test;
    import gpdz_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BATCH_ITEMS    = 100;

    class deadzone_scoreboard;
        cfg_t        regs;
        logic [15:0] button_word;
        logic [15:0] axis_word [0:AXIS_COUNT-1];
        logic [31:0] last_seen;
        rsp_item_t   awaited [$];
        int          mismatches;

        function new();
            regs.report_id       = RST_REPORT_ID;
            regs.link_timeout_ms = RST_LINK_TMO;
            regs.dead_low        = RST_DEAD_LOW;
            regs.dead_high       = RST_DEAD_HIGH;
            regs.full_scale      = RST_FULL_SCALE;
            button_word = '0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                axis_word[i] = '0;
            end
            last_seen  = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [31:0] data);
            case (index)
                CFG_REPORT_ID:  regs.report_id = data[7:0];
                CFG_LINK_TMO:   regs.link_timeout_ms = data;
                CFG_DEAD_LOW:   regs.dead_low = data[14:0];
                CFG_DEAD_HIGH:  regs.dead_high = data[14:0];
                CFG_FULL_SCALE: regs.full_scale = data[14:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] shaped_stick(logic signed [15:0] v);
            longint val;
            longint dl;
            longint dh;
            longint fs;
            longint span;
            longint num;
            val = v;
            dl = regs.dead_low;
            dh = regs.dead_high;
            fs = regs.full_scale;
            if (val >= -dl && val <= dl)
                return 16'sd0;
            if (val < -dh)
                return 16'(-fs);
            if (val > dh)
                return 16'(fs);
            span = dh - dl;
            if (span <= 0)
                return 16'sd0;
            num = (val > 0) ? (val - dl) : (val + dl);
            return 16'((num * fs) / span);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(req_item_t item);
            logic [7:0]  second_id;
            logic [31:0] age;
            rsp_item_t   result;
            second_id = regs.report_id + 8'd1;
            if (item.kind == 1'b0)
            begin
                if (item.msg_id == regs.report_id)
                begin
                    if (item.msg_length == MAIN_REPORT_LEN)
                    begin
                        button_word      = item.payload[15:0];
                        axis_word[AX_LT] = {8'd0, item.payload[23:16]};
                        axis_word[AX_RT] = {8'd0, item.payload[31:24]};
                        axis_word[AX_LX] = item.payload[47:32];
                        axis_word[AX_LY] = item.payload[63:48];
                    end
                    last_seen = item.now_ms;
                end
                else if (item.msg_id == second_id)
                begin
                    if (item.msg_length == SECOND_REPORT_LEN)
                    begin
                        axis_word[AX_RX] = item.payload[15:0];
                        axis_word[AX_RY] = item.payload[31:16];
                    end
                    last_seen = item.now_ms;
                end
                return;
            end
            result = '0;
            age = item.now_ms - last_seen;
            if (age <= regs.link_timeout_ms)
            begin
                result.connected = 1'b1;
                result.buttons   = button_word;
                if (item.axis < AXIS_COUNT)
                begin
                    result.raw_value = axis_word[item.axis];
                    if (item.axis == AX_LT || item.axis == AX_RT)
                        result.shaped_value = result.raw_value;
                    else
                        result.shaped_value = shaped_stick(result.raw_value);
                end
            end
            awaited.push_back(result);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response beat: conn=%0d buttons=%h raw=%0d shaped=%0d",
                             got.connected, got.buttons, got.raw_value, got.shaped_value);
                return;
            end
            want = awaited.pop_front();
            if (got.connected !== want.connected || got.buttons !== want.buttons ||
                got.raw_value !== want.raw_value || got.shaped_value !== want.shaped_value)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Response mismatch: expected conn=%0d buttons=%h raw=%0d shaped=%0d",
                             want.connected, want.buttons, want.raw_value, want.shaped_value);
                    $display("                   actual   conn=%0d buttons=%h raw=%0d shaped=%0d",
                             got.connected, got.buttons, got.raw_value, got.shaped_value);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_REPORT_ID;
    logic [31:0] cfg_data = '0;

    deadzone_scoreboard sb = new();
    logic [31:0] cur_ms = '0;
    bit          quiet = 1'b0;
    int          idle_count = 0;

    gamepad_report_deadzone_shaper_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp_data);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : response_back_pressure
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic req_item_t noise_item();
        req_item_t item;
        item.kind       = 1'($urandom_range(0, 1));
        item.now_ms     = $urandom();
        item.msg_id     = 8'($urandom_range(0, 255));
        item.msg_length = 8'($urandom_range(0, 255));
        item.payload    = {$urandom(), $urandom()};
        item.axis       = 3'($urandom_range(0, 7));
        return item;
    endfunction

    function automatic req_item_t main_report(logic [7:0] id, logic [7:0] len, logic [31:0] now,
                                              logic [15:0] buttons, logic [7:0] lt,
                                              logic [7:0] rt, logic [15:0] lx, logic [15:0] ly);
        req_item_t item;
        item            = noise_item();
        item.kind       = 1'b0;
        item.msg_id     = id;
        item.msg_length = len;
        item.now_ms     = now;
        item.payload    = {ly, lx, rt, lt, buttons};
        return item;
    endfunction

    function automatic req_item_t second_report(logic [7:0] id, logic [7:0] len, logic [31:0] now,
                                                logic [15:0] rx, logic [15:0] ry);
        req_item_t item;
        item                = noise_item();
        item.kind           = 1'b0;
        item.msg_id         = id;
        item.msg_length     = len;
        item.now_ms         = now;
        item.payload[31:0]  = {ry, rx};
        return item;
    endfunction

    function automatic req_item_t axis_query(logic [31:0] now, logic [2:0] axis_sel);
        req_item_t item;
        item        = noise_item();
        item.kind   = 1'b1;
        item.now_ms = now;
        item.axis   = axis_sel;
        return item;
    endfunction

    function automatic logic [15:0] pick_stick();
        logic [15:0] dl;
        logic [15:0] dh;
        dl = {1'b0, sb.regs.dead_low};
        dh = {1'b0, sb.regs.dead_high};
        case ($urandom_range(0, 13))
            0: return dl;
            1: return dl + 16'd1;
            2: return -dl;
            3: return ~dl;
            4: return dh;
            5: return dh + 16'd1;
            6: return -dh;
            7: return ~dh;
            8: return 16'h7FFF;
            9: return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void advance_time();
        case ($urandom_range(0, 9))
            0: cur_ms = $urandom();
            1: cur_ms = sb.last_seen + sb.regs.link_timeout_ms;
            2: cur_ms = sb.last_seen + sb.regs.link_timeout_ms + 32'd1;
            3, 4: ;
            default: cur_ms = cur_ms + $urandom_range(0, 60);
        endcase
    endfunction

    task automatic send(req_item_t item);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
    endtask

    task automatic wait_drained();
        if (sb.pending() != 0)
        begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clk);
        end
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(index, data);
    endtask

    task automatic configure(logic [7:0] rid, logic [31:0] tmo, logic [14:0] dl,
                             logic [14:0] dh, logic [14:0] fs);
        settle();
        write_register(CFG_REPORT_ID, {24'd0, rid});
        write_register(CFG_LINK_TMO, tmo);
        write_register(CFG_DEAD_LOW, {17'd0, dl});
        write_register(CFG_DEAD_HIGH, {17'd0, dh});
        write_register(CFG_FULL_SCALE, {17'd0, fs});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_batch(int count);
        int          pick;
        logic [7:0]  rid;
        logic [7:0]  len;
        req_item_t   item;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            rid  = sb.regs.report_id;
            advance_time();
            if (pick < 35)
                item = main_report(rid, MAIN_REPORT_LEN, cur_ms, 16'($urandom_range(0, 65535)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   pick_stick(), pick_stick());
            else if (pick < 50)
                item = second_report(rid + 8'd1, SECOND_REPORT_LEN, cur_ms,
                                     pick_stick(), pick_stick());
            else if (pick < 56)
            begin
                len = 8'($urandom_range(0, 255));
                if (len == MAIN_REPORT_LEN || len == SECOND_REPORT_LEN)
                    len = len + 8'd1;
                item = main_report($urandom_range(0, 1) ? rid : rid + 8'd1, len, cur_ms,
                                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), pick_stick(), pick_stick());
            end
            else if (pick < 61)
            begin
                item = noise_item();
                item.kind = 1'b0;
            end
            else
                item = axis_query(cur_ms, 3'($urandom_range(0, 7)));
            send(item);
            if (!quiet && $urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(axis_query(32'd0, AX_LX));
        send(axis_query(32'd101, AX_LT));
        send(main_report(8'd0, MAIN_REPORT_LEN, 32'd1000, 16'hFFFF, 8'hFF, 8'h00,
                         16'h7FFF, 16'h8000));
        for (int a = 0; a < 8; a++)
        begin
            send(axis_query(32'd1100, a[2:0]));
        end
        send(second_report(8'd1, SECOND_REPORT_LEN, 32'd2000, 16'd30001, 16'h8AD0));
        send(axis_query(32'd2000, AX_RX));
        send(axis_query(32'd2000, AX_RY));
        send(second_report(8'd1, SECOND_REPORT_LEN, 32'd2010, 16'd1000, 16'hFC17));
        send(axis_query(32'd2010, AX_RX));
        send(axis_query(32'd2010, AX_RY));
        send(main_report(8'd0, 8'd7, 32'd5000, 16'h1234, 8'h56, 8'h78, 16'h0, 16'h0));
        send(axis_query(32'd5050, AX_LX));
        send(second_report(8'd1, MAIN_REPORT_LEN, 32'd5100, 16'h0, 16'h0));
        send(main_report(8'd2, MAIN_REPORT_LEN, 32'd9000, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0));
        send(axis_query(32'd5201, AX_LY));
        send(axis_query(32'd5200, AX_RX));

        configure(8'h42, 32'hFFFF_FFFF, 15'd0, 15'h7FFF, 15'h7FFF);
        random_batch(BATCH_ITEMS);
        configure(8'hFF, 32'd0, 15'h7FFF, 15'h7FFF, 15'd0);
        send(second_report(8'd0, SECOND_REPORT_LEN, cur_ms, 16'h8000, 16'h7FFF));
        send(axis_query(cur_ms, AX_RX));
        random_batch(BATCH_ITEMS);
        configure(8'hFE, 32'd1000, 15'd5000, 15'd2000, 15'd500);
        random_batch(BATCH_ITEMS);
        configure(8'h10, 32'd60, 15'd100, 15'd101, 15'h7FFF);
        random_batch(BATCH_ITEMS);
        configure(8'($urandom_range(0, 255)), $urandom(), 15'($urandom_range(0, 32767)),
                  15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
        random_batch(BATCH_ITEMS);
        configure(RST_REPORT_ID, RST_LINK_TMO, RST_DEAD_LOW, RST_DEAD_HIGH, RST_FULL_SCALE);
        random_batch(BATCH_ITEMS / 2);
        quiet = 1'b1;
        random_batch(BATCH_ITEMS / 2);

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
